### sv/pat_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the prescaled auto-reload timer.
// No dependencies; every other file of the timer imports this package.
package pat_pkg;

  localparam int COUNTER_WIDTH   = 32;
  localparam int PRESCALER_WIDTH = 16;
  localparam int DATA_WIDTH      = 32;
  localparam int MODE_WIDTH      = 3;

  // Item kinds.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Register map.
  localparam logic [3:0] REG_CR1  = 4'd0;
  localparam logic [3:0] REG_CR2  = 4'd1;
  localparam logic [3:0] REG_SMCR = 4'd2;
  localparam logic [3:0] REG_DIER = 4'd3;
  localparam logic [3:0] REG_SR   = 4'd4;
  localparam logic [3:0] REG_EGR  = 4'd5;
  localparam logic [3:0] REG_CNT  = 4'd6;
  localparam logic [3:0] REG_PSC  = 4'd7;
  localparam logic [3:0] REG_ARR  = 4'd8;

  // Mode codes.
  localparam logic [MODE_WIDTH-1:0] MMS_UPDATE  = 3'h2;
  localparam logic [MODE_WIDTH-1:0] SMS_TRIGGER = 3'h6;

  typedef struct packed {
    logic [1:0]            action;
    logic [3:0]            reg_select;
    logic [DATA_WIDTH-1:0] write_data;
    logic                  trigger_level;
  } cmd_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_data;
    logic                  irq;
    logic                  trgo_pulse;
    logic                  counting;
  } rsp_t;

endpackage

### sv/pat_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the timer's command and response streams.
// Depends on pat_pkg for the payload types.
interface pat_cmd_if;
  import pat_pkg::*;
  logic valid;
  logic ready;
  cmd_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pat_rsp_if;
  import pat_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/pat_engine.sv
`timescale 1ns / 1ps
// Timer state and its update for one tick, write or read.
// Depends on pat_pkg.
module pat_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  pat_pkg::cmd_t cmd,
  output pat_pkg::rsp_t rsp
);
  import pat_pkg::*;

  logic                       counter_enable, counter_enable_next;
  logic                       update_request_source, update_request_source_next;
  logic                       one_pulse_mode, one_pulse_mode_next;
  logic [MODE_WIDTH-1:0]      master_mode, master_mode_next;
  logic [MODE_WIDTH-1:0]      slave_mode, slave_mode_next;
  logic                       update_irq_enable, update_irq_enable_next;
  logic                       update_flag, update_flag_next;
  logic [COUNTER_WIDTH-1:0]   count_value, count_value_next;
  logic [PRESCALER_WIDTH-1:0] prescale_preload, prescale_preload_next;
  logic [PRESCALER_WIDTH-1:0] prescale_active, prescale_active_next;
  logic [PRESCALER_WIDTH-1:0] prescale_count, prescale_count_next;
  logic [COUNTER_WIDTH-1:0]   reload_value, reload_value_next;
  logic                       trigger_previous, trigger_previous_next;

  logic                  update_event;
  logic                  enable_now;
  logic [DATA_WIDTH-1:0] read_value;

  always_comb begin
    counter_enable_next        = counter_enable;
    update_request_source_next = update_request_source;
    one_pulse_mode_next        = one_pulse_mode;
    master_mode_next           = master_mode;
    slave_mode_next            = slave_mode;
    update_irq_enable_next     = update_irq_enable;
    update_flag_next           = update_flag;
    count_value_next           = count_value;
    prescale_preload_next      = prescale_preload;
    prescale_active_next       = prescale_active;
    prescale_count_next        = prescale_count;
    reload_value_next          = reload_value;
    trigger_previous_next      = trigger_previous;
    update_event               = 1'b0;
    read_value                 = '0;
    enable_now                 = counter_enable;

    case (cmd.action)
      ACT_TICK: begin
        // A rising trigger in trigger mode starts the counter on this very tick.
        enable_now = counter_enable |
                     ((slave_mode == SMS_TRIGGER) & cmd.trigger_level & ~trigger_previous);
        counter_enable_next   = enable_now;
        trigger_previous_next = cmd.trigger_level;
        if (enable_now) begin
          if (prescale_count >= prescale_active) begin
            prescale_count_next = '0;
            if (count_value == reload_value) begin
              count_value_next     = '0;
              prescale_active_next = prescale_preload;
              update_flag_next     = 1'b1;
              update_event         = 1'b1;
              if (one_pulse_mode) begin
                counter_enable_next = 1'b0;
              end
            end else begin
              count_value_next = COUNTER_WIDTH'(count_value + 1'b1);
            end
          end else begin
            prescale_count_next = PRESCALER_WIDTH'(prescale_count + 1'b1);
          end
        end
      end
      ACT_WRITE: begin
        case (cmd.reg_select)
          REG_CR1: begin
            counter_enable_next        = cmd.write_data[0];
            update_request_source_next = cmd.write_data[2];
            one_pulse_mode_next        = cmd.write_data[3];
          end
          REG_CR2:  master_mode_next = cmd.write_data[4 +: MODE_WIDTH];
          REG_SMCR: slave_mode_next = cmd.write_data[MODE_WIDTH-1:0];
          REG_DIER: update_irq_enable_next = cmd.write_data[0];
          REG_SR:   update_flag_next = update_flag & cmd.write_data[0];
          REG_EGR: begin
            // Software update: restart the count and reload the prescaler.
            if (cmd.write_data[0]) begin
              count_value_next     = '0;
              prescale_count_next  = '0;
              prescale_active_next = prescale_preload;
              update_event         = 1'b1;
              if (!update_request_source) begin
                update_flag_next = 1'b1;
              end
            end
          end
          REG_CNT: count_value_next = cmd.write_data[COUNTER_WIDTH-1:0];
          REG_PSC: prescale_preload_next = cmd.write_data[PRESCALER_WIDTH-1:0];
          REG_ARR: reload_value_next = cmd.write_data[COUNTER_WIDTH-1:0];
          default: ;
        endcase
      end
      ACT_READ: begin
        case (cmd.reg_select)
          REG_CR1: begin
            read_value[0] = counter_enable;
            read_value[2] = update_request_source;
            read_value[3] = one_pulse_mode;
          end
          REG_CR2:  read_value[4 +: MODE_WIDTH] = master_mode;
          REG_SMCR: read_value[MODE_WIDTH-1:0] = slave_mode;
          REG_DIER: read_value[0] = update_irq_enable;
          REG_SR:   read_value[0] = update_flag;
          REG_CNT:  read_value = DATA_WIDTH'(count_value);
          REG_PSC:  read_value = DATA_WIDTH'(prescale_preload);
          REG_ARR:  read_value = DATA_WIDTH'(reload_value);
          default:  read_value = '0;
        endcase
      end
      default: ;
    endcase
  end

  assign rsp.read_data  = read_value;
  assign rsp.irq        = update_flag_next & update_irq_enable_next;
  assign rsp.trgo_pulse = update_event & (master_mode_next == MMS_UPDATE);
  assign rsp.counting   = counter_enable_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      counter_enable        <= 1'b0;
      update_request_source <= 1'b0;
      one_pulse_mode        <= 1'b0;
      master_mode           <= '0;
      slave_mode            <= '0;
      update_irq_enable     <= 1'b0;
      update_flag           <= 1'b0;
      count_value           <= '0;
      prescale_preload      <= '0;
      prescale_active       <= '0;
      prescale_count        <= '0;
      reload_value          <= '1;
      trigger_previous      <= 1'b0;
    end else if (step) begin
      counter_enable        <= counter_enable_next;
      update_request_source <= update_request_source_next;
      one_pulse_mode        <= one_pulse_mode_next;
      master_mode           <= master_mode_next;
      slave_mode            <= slave_mode_next;
      update_irq_enable     <= update_irq_enable_next;
      update_flag           <= update_flag_next;
      count_value           <= count_value_next;
      prescale_preload      <= prescale_preload_next;
      prescale_active       <= prescale_active_next;
      prescale_count        <= prescale_count_next;
      reload_value          <= reload_value_next;
      trigger_previous      <= trigger_previous_next;
    end
  end

`ifndef ASSERT_OFF
  a_trgo_needs_mms: assert property (@(posedge clk) disable iff (rst)
    rsp.trgo_pulse |-> (master_mode == MMS_UPDATE))
    else $error("trgo pulse outside master mode update");

  a_state_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(count_value) && $stable(update_flag) && $stable(counter_enable))
    else $error("timer state changed without an item");

  a_tick_update_wraps: assert property (@(posedge clk) disable iff (rst)
    (step && cmd.action == ACT_TICK && update_event) |=> (count_value == '0) && update_flag)
    else $error("update event did not wrap counter and set flag");

  a_stopped_tick_holds: assert property (@(posedge clk) disable iff (rst)
    (step && cmd.action == ACT_TICK && !enable_now) |=> $stable(count_value) &&
    $stable(prescale_count))
    else $error("stopped counter moved on a tick");
`endif

endmodule

### sv/prescaled_autoreload_timer_core.sv
`timescale 1ns / 1ps
// Prescaled auto-reload timer: a command transfer passes first through the command register,
// then through the update logic into the response register. Throughput is one command per
// cycle unless the response stalls; the state update for one item is combinational.
// Reset (rst, synchronous, active high) stops the counter and clears the timer registers but
// sets the auto-reload value to all ones; no response is pending afterwards.
// Depends on pat_pkg, pat_if and pat_engine.
module prescaled_autoreload_timer_core (
  input  logic          clk,
  input  logic          rst,
  pat_cmd_if.sink       cmd,
  pat_rsp_if.source     rsp
);
  import pat_pkg::*;

  // Command register: holds the accepted transfer until the update logic consumes it.
  logic cmd_valid;
  cmd_t cmd_q;

  // Response register: parts the response side from the command side so a stalled
  // response does not block commands one register deep.
  logic rsp_valid;
  rsp_t rsp_q;
  rsp_t rsp_next;

  // The pipeline moves whenever the response register is empty or being drained.
  logic advance;
  logic step;

  assign advance   = !rsp_valid || rsp.ready;
  assign step      = cmd_valid && advance;
  assign cmd.ready = !cmd_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (cmd.ready) begin
      cmd_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      cmd_q <= cmd.data;
    end
  end

  // The engine holds all timer state and commits it only on a step, so every
  // command is applied exactly once and in order.
  pat_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (cmd_q),
    .rsp  (rsp_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_q <= rsp_next;
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_q;

`ifndef ASSERT_OFF
  a_cmd_held_on_stall: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !advance) |=> cmd_valid && $stable(cmd_q))
    else $error("command register lost its item during a stall");

  a_rsp_from_step: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(step))
    else $error("response appeared without a consumed command");

  a_step_refills: assert property (@(posedge clk) disable iff (rst)
    step |=> rsp_valid)
    else $error("processed command produced no response");
`endif

endmodule
